// ===== sv/efu_pkg.sv =====
// Package for the escaped frame unpacker: byte codes, phase and status codes,
// the queued result entry type and the byte-wide CRC-32 update.
// No dependencies; used by escaped_frame_unpacker_crc32_unit.
package efu_pkg;

	localparam logic [7:0]  SyncA    = 8'h55;
	localparam logic [7:0]  SyncB    = 8'hAA;
	localparam logic [7:0]  EscChar  = 8'h7D;
	localparam logic [7:0]  FlagChar = 8'h7E;
	localparam logic [7:0]  EscLoA   = 8'h5D;
	localparam logic [7:0]  EscLoB   = 8'h5E;
	localparam logic [7:0]  EscXor   = 8'h20;
	localparam logic [31:0] CrcPoly  = 32'hEDB88320;
	localparam logic [31:0] CrcInit  = 32'hFFFFFFFF;

	// Result queue depth and the pointer width that follows from it.
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned PtrW      = $clog2(FifoDepth);
	localparam int unsigned CntW      = $clog2(FifoDepth + 1);

	typedef enum logic [7:0] {
		PH_HUNT_A  = 8'b0000_0001,
		PH_HUNT_B  = 8'b0000_0010,
		PH_LEN_LO  = 8'b0000_0100,
		PH_LEN_HI  = 8'b0000_1000,
		PH_OUTSIDE = 8'b0001_0000,
		PH_INSIDE  = 8'b0010_0000,
		PH_ESCAPE  = 8'b0100_0000,
		PH_DISCARD = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		ST_CRC_OK    = 3'd0,
		ST_CRC_BAD   = 3'd1,
		ST_FLAG      = 3'd2,
		ST_ESCAPE    = 3'd3,
		ST_TOO_SHORT = 3'd4
	} status_t;

	// One queued entry: an optional payload byte followed by an optional status.
	typedef struct packed {
		logic        has_data;
		logic [7:0]  data_byte;
		logic        has_status;
		status_t     status;
		logic [15:0] payload_count;
	} entry_t;

	// Reflected CRC-32 over one byte, eight shift steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
		input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'h00000000);
		end
		return c;
	endfunction

endpackage

// ===== sv/escaped_frame_unpacker_crc32_unit.sv =====
// Top level of the escaped frame unpacker: sync hunt, length, byte unstuffing,
// 4-byte hold-back, CRC-32 check and a small result queue.
// Depends on efu_pkg.
//
// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
// m_axis   out  m_axis_tvalid/m_axis_tready   tlast frame_end, tdata data_byte,
//                                             status, payload_count
//
// One received item is taken per cycle while s_axis_tready is high. An accepted
// item is registered in stage s1 and decoded there; its results (a payload
// byte and/or a status) go into a four-entry queue as one entry. The output
// side drains one result per cycle while m_axis_tready is high. The input
// stalls only when the queue together with the item in s1 could overflow.
// arst_n clears the phase, counters and queue pointers.
module escaped_frame_unpacker_crc32_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status,
	                                    // [26:11] payload_count, [31:27] zero
	output logic        m_axis_tlast    // frame_end
);

	// Input register stage.
	logic              valid_s1;
	logic [7:0]        rx_s1;

	// Deframer state.
	efu_pkg::phase_t   phase_q, phase_nx;
	logic [15:0]       left_q, left_nx;
	logic [31:0]       crc_q, crc_nx;
	logic [3:0][7:0]   hb_q, hb_nx;
	logic [2:0]        fill_q, fill_nx;
	logic [15:0]       cnt_q, cnt_nx;
	efu_pkg::entry_t   ent;
	logic              push;

	// Result queue.
	efu_pkg::entry_t                 fifo_q [efu_pkg::FifoDepth];
	logic [efu_pkg::PtrW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [efu_pkg::CntW-1:0]        fcnt_q;
	logic                            second_q;
	efu_pkg::entry_t                 head;
	logic                            out_fire, pop, show_data;

	// Accept while the queue has room for the item already in s1 and this one.
	assign s_axis_tready = (fcnt_q + efu_pkg::CntW'(valid_s1))
		< efu_pkg::CntW'(efu_pkg::FifoDepth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			rx_s1 <= s_axis_tdata;
		end
	end

	// Decode of the byte in s1 against the current phase.
	always_comb begin
		logic        has;
		logic [2:0]  err;
		logic [7:0]  db;
		logic [15:0] len;
		logic [15:0] left_dec;
		has      = 1'b0;
		err      = 3'd0;
		db       = rx_s1;
		len      = {rx_s1, left_q[7:0]};
		left_dec = left_q - 16'd1;
		phase_nx = phase_q;
		left_nx  = left_q;
		crc_nx   = crc_q;
		hb_nx    = hb_q;
		fill_nx  = fill_q;
		cnt_nx   = cnt_q;
		ent      = '0;
		case (phase_q)
			efu_pkg::PH_HUNT_B: begin
				if (rx_s1 == efu_pkg::SyncB) begin
					phase_nx = efu_pkg::PH_LEN_LO;
				end else if (rx_s1 != efu_pkg::SyncA) begin
					phase_nx = efu_pkg::PH_HUNT_A;
				end
			end
			efu_pkg::PH_LEN_LO: begin
				left_nx  = {8'h00, rx_s1};
				phase_nx = efu_pkg::PH_LEN_HI;
			end
			efu_pkg::PH_LEN_HI: begin
				left_nx = len;
				if (len == 16'd0) begin
					ent.has_status = 1'b1;
					ent.status     = efu_pkg::ST_TOO_SHORT;
					phase_nx       = efu_pkg::PH_HUNT_A;
				end else begin
					crc_nx   = efu_pkg::CrcInit;
					fill_nx  = 3'd0;
					cnt_nx   = 16'd0;
					phase_nx = efu_pkg::PH_OUTSIDE;
				end
			end
			efu_pkg::PH_OUTSIDE, efu_pkg::PH_INSIDE, efu_pkg::PH_ESCAPE: begin
				if (phase_q == efu_pkg::PH_ESCAPE) begin
					if (rx_s1 == efu_pkg::EscLoA || rx_s1 == efu_pkg::EscLoB) begin
						db       = rx_s1 ^ efu_pkg::EscXor;
						has      = 1'b1;
						phase_nx = efu_pkg::PH_INSIDE;
					end else begin
						err = efu_pkg::ST_ESCAPE;
					end
				end else if (!(phase_q == efu_pkg::PH_OUTSIDE
					&& rx_s1 == efu_pkg::FlagChar)) begin
					if (rx_s1 == efu_pkg::EscChar) begin
						phase_nx = efu_pkg::PH_ESCAPE;
					end else if (rx_s1 == efu_pkg::FlagChar) begin
						// A flag is legal only two bytes before the frame end.
						if (left_q == 16'd2) begin
							phase_nx = efu_pkg::PH_OUTSIDE;
						end else begin
							err = efu_pkg::ST_FLAG;
						end
					end else begin
						phase_nx = efu_pkg::PH_INSIDE;
						has      = 1'b1;
					end
				end
				if (has) begin
					if (fill_q[2]) begin
						// Hold-back full: the oldest byte leaves as payload.
						ent.has_data  = 1'b1;
						ent.data_byte = hb_q[0];
						crc_nx        = efu_pkg::crc32_byte(crc_q, hb_q[0]);
						cnt_nx        = cnt_q + 16'd1;
						hb_nx         = {db, hb_q[3:1]};
					end else begin
						hb_nx[fill_q[1:0]] = db;
						fill_nx            = fill_q + 3'd1;
					end
				end
				left_nx = left_dec;
				if (err != 3'd0) begin
					ent.has_status = 1'b1;
					ent.status     = efu_pkg::status_t'(err);
					phase_nx = (left_dec != 16'd0) ? efu_pkg::PH_DISCARD
						: efu_pkg::PH_HUNT_A;
				end else if (left_dec == 16'd0) begin
					ent.has_status = 1'b1;
					if (!fill_nx[2]) begin
						ent.status = efu_pkg::ST_TOO_SHORT;
					end else begin
						// The held-back bytes are the received CRC, low byte first.
						ent.status = ((~crc_nx) == hb_nx) ? efu_pkg::ST_CRC_OK
							: efu_pkg::ST_CRC_BAD;
						ent.payload_count = cnt_nx;
					end
					phase_nx = efu_pkg::PH_HUNT_A;
				end
			end
			efu_pkg::PH_DISCARD: begin
				left_nx = left_dec;
				if (left_dec == 16'd0) begin
					phase_nx = efu_pkg::PH_HUNT_A;
				end
			end
			default: begin
				phase_nx = (rx_s1 == efu_pkg::SyncA) ? efu_pkg::PH_HUNT_B
					: efu_pkg::PH_HUNT_A;
			end
		endcase
	end

	assign push = valid_s1 && (ent.has_data || ent.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= efu_pkg::PH_HUNT_A;
			left_q  <= 16'd0;
			crc_q   <= efu_pkg::CrcInit;
			fill_q  <= 3'd0;
			cnt_q   <= 16'd0;
		end else if (valid_s1) begin
			phase_q <= phase_nx;
			left_q  <= left_nx;
			crc_q   <= crc_nx;
			fill_q  <= fill_nx;
			cnt_q   <= cnt_nx;
		end
	end

	// Hold-back bytes are only read once all four have been written.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hb_q <= hb_nx;
		end
	end

	// Output side: an entry with both results shows the byte first.
	assign head      = fifo_q[rd_ptr_q];
	assign show_data = head.has_data && !second_q;
	assign out_fire  = m_axis_tvalid && m_axis_tready;
	assign pop       = out_fire && !(show_data && head.has_status);

	assign m_axis_tvalid = (fcnt_q != '0);
	assign m_axis_tlast  = !show_data;
	assign m_axis_tdata  = show_data
		? {24'h000000, head.data_byte}
		: {5'b00000, head.payload_count, head.status, 8'h00};

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
			second_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fcnt_q <= fcnt_q + efu_pkg::CntW'(push) - efu_pkg::CntW'(pop);
			if (pop) begin
				second_q <= 1'b0;
			end else if (out_fire) begin
				second_q <= 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fcnt_q < efu_pkg::CntW'(efu_pkg::FifoDepth))
		else $error("result queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= efu_pkg::CntW'(efu_pkg::FifoDepth))
		else $error("result queue count out of range");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd4)
		else $error("hold-back fill out of range");

	a_second_pair: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> m_axis_tvalid && head.has_data && head.has_status)
		else $error("second beat without a paired entry");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && ent.has_status && ent.status != efu_pkg::ST_CRC_OK
		&& ent.status != efu_pkg::ST_CRC_BAD |-> ent.payload_count == 16'd0)
		else $error("error status with nonzero count");
`endif

endmodule
